FILE: design/ntw_pkg.sv
package ntw_pkg;

  localparam int VALUE_W        = 60;
  localparam int WORD_W         = 6;
  localparam int MAX_DIGITS_DEF = 18;

  // word codes
  localparam logic [WORD_W-1:0] W_ZERO      = 6'd0;
  localparam logic [WORD_W-1:0] W_TEEN_BASE = 6'd10;
  localparam logic [WORD_W-1:0] W_TWENTY    = 6'd20;
  localparam logic [WORD_W-1:0] W_TENS_BASE = 6'd18;
  localparam logic [WORD_W-1:0] W_HUNDRED   = 6'd28;
  localparam logic [WORD_W-1:0] W_SCALE0    = 6'd28;
  localparam logic [WORD_W-1:0] W_OH        = 6'd34;
  localparam logic [WORD_W-1:0] W_PERCENT   = 6'd35;

  // year reading window
  localparam logic [11:0] YEAR_LO = 12'd1000;
  localparam logic [11:0] YEAR_HI = 12'd2099;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ordinal;
    logic               percent;
    logic               year_eligible;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              ordinal_form;
    logic              last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_CARD,
    S_YEAR,
    S_FLUSH,
    S_PCT
  } state_t;

  // steps within one group of three digits; the year reading reuses the first three
  typedef enum logic [2:0] {
    P_HDIG,
    P_HWORD,
    P_TENS,
    P_ONES,
    P_SCALE
  } phase_t;

  // largest value with n decimal digits, evaluated at elaboration
  function automatic logic [VALUE_W-1:0] dec_limit(input int n);
    logic [VALUE_W-1:0] r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r - 1'b1;
  endfunction

endpackage

FILE: design/number_to_word_tokens.sv
// The converter shifts two bits a cycle into its digit register. One request at a time: the
// sequencer walks each nonzero three-digit group of a cardinal reading through its hundreds
// digit, hundred, tens, ones and scale steps and skips a zero group (six groups by default),
// then takes a flush step and, for a percent request, a percent step. Busy drops in the cycle
// that carries the last word, so the next request can be taken in that cycle. The receiver
// cannot stall. Reset (rst, synchronous) idles the sequencer, drops pending words.
module number_to_word_tokens import ntw_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  request,
  output logic busy,
  output out_t result,
  output logic result_valid
);

  localparam int NG    = (MAX_DIGITS + 2) / 3;
  localparam int BCD_W = 12 * NG;
  localparam int GI_W  = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [VALUE_W-1:0] LIMIT = dec_limit(MAX_DIGITS);
  localparam bit YEAR_FITS = (MAX_DIGITS >= 4);

  state_t state, state_next;
  phase_t phase, phase_next;

  logic               ord, pct, yr;
  logic [BCD_W-1:0]   bcd_sh;
  logic [GI_W-1:0]    gi;
  logic [WORD_W-1:0]  pend_word;
  logic               pend_valid;

  logic               conv_load, conv_done;
  logic [BCD_W-1:0]   conv_bcd;
  logic [VALUE_W-1:0] value_sat;
  logic               year_ok;

  logic               gen_valid;
  logic [WORD_W-1:0]  gen_word;
  logic               grp_adv;
  logic               load_digits;
  logic               out_valid_next;
  out_t               out_next;

  logic [3:0]         h, t, o;
  logic               gz;
  logic [15:0]        yd, ydc;
  logic [WORD_W-1:0]  yhi;

  // clamp oversize values and qualify the year reading
  always_comb begin
    value_sat = (request.value > LIMIT) ? LIMIT : request.value;
    year_ok   = YEAR_FITS && request.year_eligible && !request.ordinal &&
                (request.value[VALUE_W-1:12] == '0) &&
                (request.value[11:0] >= YEAR_LO) && (request.value[11:0] <= YEAR_HI);
  end

  ntw_bcd_conv #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_conv (
    .clk  (clk),
    .rst  (rst),
    .load (conv_load),
    .value(value_sat),
    .done (conv_done),
    .bcd  (conv_bcd)
  );

  // digits of the current group and of a year
  always_comb begin
    h   = bcd_sh[BCD_W-1 -: 4];
    t   = bcd_sh[BCD_W-5 -: 4];
    o   = bcd_sh[BCD_W-9 -: 4];
    gz  = (bcd_sh[BCD_W-1 -: 12] == 12'd0);
    yd  = 16'(bcd_sh);
    ydc = 16'(conv_bcd);
    yhi = (yd[15:12] == 4'd1) ? W_TEEN_BASE + WORD_W'(yd[11:8]) : W_TWENTY;
  end

  assign busy = (state != S_IDLE);

  // sequencer: next state, generated word and output word
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    gen_valid      = 1'b0;
    gen_word       = W_ZERO;
    grp_adv        = 1'b0;
    conv_load      = 1'b0;
    load_digits    = 1'b0;
    out_valid_next = 1'b0;
    out_next       = '{word: pend_word, ordinal_form: 1'b0, last: 1'b0};

    case (state)
      S_IDLE: begin
        if (start) begin
          conv_load  = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          load_digits = 1'b1;
          phase_next  = P_HDIG;
          if (conv_bcd == '0) begin
            gen_valid  = 1'b1;
            gen_word   = W_ZERO;
            state_next = S_FLUSH;
          end else if (yr && !(ydc[7:0] == 8'd0 && ydc[11:8] == 4'd0)) begin
            state_next = S_YEAR;
          end else begin
            state_next = S_CARD;
          end
        end
      end
      S_CARD: begin
        case (phase)
          P_HDIG: begin
            if (gz) begin
              grp_adv = 1'b1;
            end else begin
              gen_valid  = (h != 4'd0);
              gen_word   = WORD_W'(h);
              phase_next = P_HWORD;
            end
          end
          P_HWORD: begin
            gen_valid  = (h != 4'd0);
            gen_word   = W_HUNDRED;
            phase_next = P_TENS;
          end
          P_TENS: begin
            if (t == 4'd1) begin
              gen_valid = 1'b1;
              gen_word  = W_TEEN_BASE + WORD_W'(o);
            end else if (t != 4'd0) begin
              gen_valid = 1'b1;
              gen_word  = W_TENS_BASE + WORD_W'(t);
            end
            phase_next = P_ONES;
          end
          P_ONES: begin
            gen_valid  = (t != 4'd1) && (o != 4'd0);
            gen_word   = WORD_W'(o);
            phase_next = P_SCALE;
          end
          P_SCALE: begin
            gen_valid = (gi != '0);
            gen_word  = W_SCALE0 + WORD_W'(gi);
            grp_adv   = 1'b1;
          end
          default: begin
            grp_adv = 1'b1;
          end
        endcase
        if (grp_adv) begin
          if (gi == '0) begin
            state_next = S_FLUSH;
          end else begin
            phase_next = P_HDIG;
          end
        end
      end
      S_YEAR: begin
        case (phase)
          P_HDIG: begin
            gen_valid  = 1'b1;
            gen_word   = yhi;
            phase_next = P_HWORD;
          end
          P_HWORD: begin
            gen_valid = 1'b1;
            if (yd[7:0] == 8'd0) begin
              gen_word   = W_HUNDRED;
              state_next = S_FLUSH;
            end else if (yd[7:4] == 4'd0) begin
              gen_word   = W_OH;
              phase_next = P_TENS;
            end else if (yd[7:4] == 4'd1) begin
              gen_word   = W_TEEN_BASE + WORD_W'(yd[3:0]);
              state_next = S_FLUSH;
            end else begin
              gen_word = W_TENS_BASE + WORD_W'(yd[7:4]);
              if (yd[3:0] == 4'd0) begin
                state_next = S_FLUSH;
              end else begin
                phase_next = P_TENS;
              end
            end
          end
          default: begin
            gen_valid  = 1'b1;
            gen_word   = WORD_W'(yd[3:0]);
            state_next = S_FLUSH;
          end
        endcase
      end
      S_FLUSH: begin
        out_valid_next = 1'b1;
        out_next       = '{word: pend_word, ordinal_form: ord, last: !pct};
        state_next     = pct ? S_PCT : S_IDLE;
      end
      S_PCT: begin
        out_valid_next = 1'b1;
        out_next       = '{word: W_PERCENT, ordinal_form: 1'b0, last: 1'b1};
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // release the held word once a newer one arrives
    if (gen_valid && pend_valid) begin
      out_valid_next = 1'b1;
      out_next       = '{word: pend_word, ordinal_form: 1'b0, last: 1'b0};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= P_HDIG;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      result_valid <= out_valid_next;
      if (conv_load) begin
        pend_valid <= 1'b0;
      end else if (gen_valid) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // payload: request flags, digit window, held word, result
  always_ff @(posedge clk) begin
    result <= out_next;
    if (conv_load) begin
      ord <= request.ordinal;
      pct <= request.percent && !request.ordinal;
      yr  <= year_ok;
    end
    if (gen_valid) begin
      pend_word <= gen_word;
    end
    if (load_digits) begin
      bcd_sh <= conv_bcd;
      gi     <= GI_W'(NG - 1);
    end else if (grp_adv && gi != '0) begin
      bcd_sh <= {bcd_sh[BCD_W-13:0], 12'd0};
      gi     <= gi - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_last_frees_block: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("block still busy after the last word");

  a_percent_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.word == W_PERCENT |-> result.last && !result.ordinal_form)
    else $error("percent word not final or marked ordinal");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");
`endif

endmodule

FILE: design/ntw_bcd_conv.sv
module ntw_bcd_conv import ntw_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [VALUE_W-1:0]                value,
  output logic                              done,
  output logic [4*3*((MAX_DIGITS+2)/3)-1:0] bcd
);

  localparam int NG    = (MAX_DIGITS + 2) / 3;
  localparam int ND    = 3 * NG;
  localparam int BCD_W = 4 * ND;
  localparam int STEPS = VALUE_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd_r;
  logic [CNT_W-1:0]   cnt;
  logic               running;
  logic [BCD_W-1:0]   a1, s1, a2, s2;

  // add three to every digit of five or more before a shift
  function automatic logic [BCD_W-1:0] adjust(input logic [BCD_W-1:0] b);
    logic [3:0]       d;
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < ND; i++) begin
      d = b[4*i +: 4];
      r[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
    return r;
  endfunction

  // shift two binary bits into the digit register per cycle while a conversion runs
  always_comb begin
    a1 = adjust(bcd_r);
    s1 = {a1[BCD_W-2:0], bin[VALUE_W-1]};
    a2 = adjust(s1);
    s2 = {a2[BCD_W-2:0], bin[VALUE_W-2]};
  end

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // binary and digit shift registers
  always_ff @(posedge clk) begin
    if (load) begin
      bin   <= value;
      bcd_r <= '0;
    end else if (running) begin
      bin   <= {bin[VALUE_W-3:0], 2'b00};
      bcd_r <= s2;
    end
  end

  assign bcd = bcd_r;

endmodule
